[rtl/lms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lms_pkg;

  // field and storage widths
  localparam int OP_W    = 2;
  localparam int ADC_W   = 14;
  localparam int NOISE_W = 12;
  localparam int DAC_W   = 14;
  localparam int STEP_W  = 16;
  localparam int W_W     = 24;   // weight, signed q1.23
  localparam int X_W     = 12;   // excitation, signed q.15 in 12 bits, always within +-1638

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1049;

  // op codes, readout is decoded by the high bit
  localparam logic [OP_W-1:0] OP_ADAPT = 2'd0;
  localparam int OP_READ_BIT = 1;

  // excitation: floor((noise*8 + 3621) / 10) - 2000, division by reciprocal
  localparam logic [15:0]       EXC_BIAS  = 16'd3621;
  localparam logic [STEP_W:0]   RECIP_10  = 17'd52429;
  localparam int                RECIP_SH  = 19;
  localparam int                X_OFFSET  = 2000;

  localparam int DAC_MID = 8192;
  localparam int DAC_MAX = 16383;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXC,
    ST_LDX,
    ST_MAC,
    ST_ERR,
    ST_SEM,
    ST_SEL,
    ST_UPD,
    ST_SHIFT,
    ST_CLR,
    ST_RD,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

[rtl/lms_system_identifier.sv]
// adapt, clear and readout items are handled one at a time: a new item is taken
//   only in the idle state, which the sequencer re-enters when the result is
//   registered in the output register
// the single shared multiplier serves one pass over the taps for the estimate
//   and one for the weight update, one tap per cycle
// synchronous active-high reset zeroes weights, delay line and readout pointer
//   and loads step_size with 1049; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module lms_system_identifier
  import lms_pkg::*;
#(
  parameter int TAPS = 50
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // step size register
  input  wire logic               step_size_we,
  input  wire logic [STEP_W-1:0]  step_size_data,
  // input items
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_W-1:0]    op,
  input  wire logic [ADC_W-1:0]   adc_code,
  input  wire logic [NOISE_W-1:0] noise_code,
  // result items
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DAC_W-1:0]        dac_code
);

  // counter runs 0..TAPS over a pass, pointer 0..TAPS-1
  localparam int CNT_W  = $clog2(TAPS + 1);
  localparam int PTR_W  = $clog2(TAPS);
  // w*x product and the estimate sum
  localparam int PROD_W = W_W + X_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  // adc value scaled to q.38 needs 39 bits signed
  localparam int ADC_SH = 25;
  localparam int ADC_TW = ADC_W + ADC_SH;
  localparam int EF_W   = ((ACC_W > ADC_TW) ? ACC_W : ADC_TW) + 1;
  localparam int E_W    = EF_W - 14;
  // shared multiplier operands
  localparam int MB_W   = STEP_W + 1;
  localparam int SE_W   = E_W + MB_W;
  localparam int MA_W   = SE_W;
  localparam int P_W    = MA_W + MB_W;
  // weight increment after the 2^-35 rounding
  localparam int DL_W   = P_W - 34;
  localparam int SUM_W  = DL_W + 1;
  localparam int WD_W   = W_W - 8;

  state_t state, state_next;

  logic [CNT_W-1:0]   cnt;
  logic [PTR_W-1:0]   ptr;
  logic [STEP_W-1:0]  step;
  logic [OP_W-1:0]    op_q;
  logic [ADC_W-1:0]   adc_q;
  logic [NOISE_W-1:0] noise_q;
  logic [DAC_W-1:0]   res_q;

  // weights and delay line live in two rings; a pass rotates them once so the
  // current tap always sits at position 0
  logic signed [W_W-1:0] wring [TAPS];
  logic signed [X_W-1:0] xring [TAPS];

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [E_W-1:0]   err;
  logic signed [SE_W-1:0]  se;

  // control from the output decoder
  logic rot_x, rot_w, upd_sel, clr_w, shift_x, load_x0, fin_ok, last;

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------

  // excitation offset value before the reciprocal multiply
  logic [15:0] exc_d;
  assign exc_d = {1'b0, noise_q, 3'b000} + EXC_BIAS;

  // quotient from the product, then remove the offset
  logic signed [X_W:0]   x0_w;
  logic signed [X_W-1:0] x0;
  assign x0_w = $signed({1'b0, prod_q[RECIP_SH +: X_W]}) - (X_W + 1)'(X_OFFSET);
  assign x0   = x0_w[X_W-1:0];

  // excitation dac code: mid + round(x0/4), never near the rails
  logic signed [X_W:0]   xr;
  logic [DAC_W-1:0]      exc_dac;
  assign xr      = $signed({x0[X_W-1], x0}) + (X_W + 1)'(2);
  assign exc_dac = DAC_W'($signed({{(DAC_W - X_W + 1){xr[X_W]}}, xr[X_W:2]}))
                   + DAC_W'(DAC_MID);

  // weight dac code: mid + round(w/1024), saturated
  logic signed [W_W:0]   wr;
  logic signed [WD_W-1:0] wd;
  logic [DAC_W-1:0]      w_dac;
  assign wr = $signed({wring[0][W_W-1], wring[0]}) + (W_W + 1)'(512);
  assign wd = $signed({wr[W_W], wr[W_W:10]}) + WD_W'(DAC_MID);
  always_comb begin
    if (wd < 0) begin
      w_dac = '0;
    end else if (wd > WD_W'(DAC_MAX)) begin
      w_dac = DAC_W'(DAC_MAX);
    end else begin
      w_dac = wd[DAC_W-1:0];
    end
  end

  // error: adc*2^25 - estimate in q.38, rounded to q.23
  logic signed [EF_W-1:0] adc_term;
  logic signed [EF_W-1:0] ef;
  logic signed [EF_W:0]   ef_r;
  assign adc_term = $signed({{(EF_W - ADC_TW){~adc_q[ADC_W-1]}}, ~adc_q[ADC_W-1],
                             adc_q[ADC_W-2:0], {ADC_SH{1'b0}}});
  assign ef   = adc_term - $signed({{(EF_W - ACC_W){acc[ACC_W-1]}}, acc});
  assign ef_r = $signed({ef[EF_W-1], ef}) + $signed({{(EF_W - 14){1'b0}}, 1'b1, 14'd0});

  // weight update: w + round(step*e*x / 2^35), saturated to q1.23
  logic signed [P_W:0]    p_rnd;
  logic signed [DL_W-1:0] delta;
  logic signed [SUM_W-1:0] w_sum;
  logic signed [W_W-1:0]  w_upd;
  logic                   w_ovf;
  assign p_rnd = $signed({prod_q[P_W-1], prod_q})
                 + $signed({{(P_W - 34){1'b0}}, 1'b1, 34'd0});
  assign delta = p_rnd[P_W:35];
  assign w_sum = $signed({delta[DL_W-1], delta})
                 + $signed({{(SUM_W - W_W){wring[0][W_W-1]}}, wring[0]});
  assign w_ovf = !((&w_sum[SUM_W-1:W_W-1]) || !(|w_sum[SUM_W-1:W_W-1]));
  always_comb begin
    if (w_ovf) begin
      w_upd = w_sum[SUM_W-1] ? $signed({1'b1, {(W_W - 1){1'b0}}})
                             : $signed({1'b0, {(W_W - 1){1'b1}}});
    end else begin
      w_upd = w_sum[W_W-1:0];
    end
  end

  logic signed [W_W-1:0] w_tail;
  assign w_tail = upd_sel ? w_upd : wring[0];

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------

  assign last = (cnt == CNT_W'(TAPS));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = op[OP_READ_BIT] ? ST_RD : ST_EXC;
        end
      end
      ST_EXC:   state_next = ST_LDX;
      ST_LDX:   state_next = (op_q == OP_ADAPT) ? ST_MAC : ST_CLR;
      ST_MAC:   if (last) state_next = ST_ERR;
      ST_ERR:   state_next = ST_SEM;
      ST_SEM:   state_next = ST_SEL;
      ST_SEL:   state_next = ST_UPD;
      ST_UPD:   if (last) state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_FIN;
      ST_CLR:   state_next = ST_FIN;
      ST_RD:    if (cnt == CNT_W'(TAPS - 1)) state_next = ST_FIN;
      ST_FIN:   if (fin_ok) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs and shared multiplier operand select
  // ---------------------------------------------------------------------------

  assign fin_ok = !out_valid || !out_stall;

  always_comb begin
    in_stall = 1'b1;
    rot_x    = 1'b0;
    rot_w    = 1'b0;
    upd_sel  = 1'b0;
    clr_w    = 1'b0;
    shift_x  = 1'b0;
    load_x0  = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EXC: begin
        // divide by ten through the reciprocal
        mul_a = $signed({{(MA_W - 16){1'b0}}, exc_d});
        mul_b = $signed(RECIP_10);
      end
      ST_LDX: load_x0 = 1'b1;
      ST_MAC: begin
        rot_x = !last;
        rot_w = !last;
        mul_a = $signed({{(MA_W - W_W){wring[0][W_W-1]}}, wring[0]});
        mul_b = $signed({{(MB_W - X_W){xring[0][X_W-1]}}, xring[0]});
      end
      ST_SEM: begin
        mul_a = $signed({{(MA_W - E_W){err[E_W-1]}}, err});
        mul_b = $signed({1'b0, step});
      end
      ST_UPD: begin
        // x ring runs one tap ahead of the weight ring
        rot_x   = !last;
        rot_w   = (cnt != '0);
        upd_sel = 1'b1;
        mul_a   = se;
        mul_b   = $signed({{(MB_W - X_W){xring[0][X_W-1]}}, xring[0]});
      end
      ST_SHIFT: shift_x = 1'b1;
      ST_CLR: begin
        clr_w   = 1'b1;
        shift_x = 1'b1;
      end
      ST_RD:    rot_w = 1'b1;
      ST_ERR, ST_SEL, ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ptr   <= '0;
      step  <= STEP_RESET;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == ST_MAC || state == ST_UPD || state == ST_RD) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (step_size_we) begin
        step <= step_size_data;
      end
      // readout pointer steps before the weight is picked
      if (state == ST_IDLE && in_valid && op[OP_READ_BIT]) begin
        ptr <= (ptr == PTR_W'(TAPS - 1)) ? '0 : ptr + PTR_W'(1);
      end
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
  end

  // item capture and per-item working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_q    <= op;
      adc_q   <= adc_code;
      noise_q <= noise_code;
    end
    if (load_x0) begin
      acc   <= '0;
      res_q <= exc_dac;
    end else if (state == ST_MAC && cnt != '0) begin
      acc <= acc + $signed({{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:0]});
    end
    if (state == ST_RD && cnt == CNT_W'(ptr)) begin
      res_q <= w_dac;
    end
    if (state == ST_ERR) begin
      err <= ef_r[EF_W:15];
    end
    if (state == ST_SEL) begin
      se <= prod_q[SE_W-1:0];
    end
  end

  // weight and delay rings
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        wring[k] <= '0;
        xring[k] <= '0;
      end
    end else begin
      if (clr_w) begin
        for (int k = 0; k < TAPS; k++) begin
          wring[k] <= '0;
        end
      end else if (rot_w) begin
        for (int k = 0; k < TAPS - 1; k++) begin
          wring[k] <= wring[k+1];
        end
        wring[TAPS-1] <= w_tail;
      end
      if (load_x0) begin
        xring[0] <= x0;
      end else if (rot_x) begin
        for (int k = 0; k < TAPS - 1; k++) begin
          xring[k] <= xring[k+1];
        end
        xring[TAPS-1] <= xring[0];
      end else if (shift_x) begin
        // head keeps its value, it is rewritten by the next excitation
        for (int k = 1; k < TAPS; k++) begin
          xring[k] <= xring[k-1];
        end
      end
    end
  end

  // output register, frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && fin_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && fin_ok) begin
      dac_code <= res_q;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != ST_IDLE)
    else $error("accepted item did not start the sequencer");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && fin_ok |=> out_valid && state == ST_IDLE)
    else $error("finished item not moved to the output register");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TAPS))
    else $error("tap counter out of range");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(TAPS - 1))
    else $error("readout pointer out of range");

endmodule

`default_nettype wire
